@@ sv/assert_macros.svh @@
// Assertion macros shared by the codec modules.
// Each macro expects a clock named clk and an active-high reset named rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ZVC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// An implication checked in the same cycle.
`define ZVC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// An implication whose consequent is checked in the cycle after the antecedent.
`define ZVC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/zvc_pkg.sv @@
// Shared types and constants of the zig-zag varint codec.
// Used by the controller, the datapath and the top level; depends on nothing.
package zvc_pkg;

  // Operation codes of an input transaction.
  localparam logic OP_ENCODE = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  // Status codes of a result transaction.
  localparam logic [1:0] ST_BYTE     = 2'd0;
  localparam logic [1:0] ST_VALUE    = 2'd1;
  localparam logic [1:0] ST_TRUNC    = 2'd2;
  localparam logic [1:0] ST_OVERLONG = 2'd3;

  // Varint byte layout and length limit.
  localparam logic [7:0] PAYLOAD_MASK = 8'h7F;
  localparam logic [7:0] CONT_BIT     = 8'h80;
  localparam logic [3:0] MAX_BYTES    = 4'd10;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic enc_load;  // Load the zig-zag mapped value into the shift register.
    logic enc_emit;  // Emit the low group as a result and shift by one group.
    logic dec_step;  // Take one decode byte into the accumulator.
  } zvc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic enc_final;  // The shift register holds the last group.
    logic dec_done;   // The current decode byte produces a result.
  } zvc_sts_t;

endpackage

@@ sv/zvc_ctrl.sv @@
// Controller of the zig-zag varint codec: input/output handshake and encode sequencing.
// Depends on zvc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module zvc_ctrl import zvc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  logic     operation,
  output logic     out_valid,
  input  logic     out_stall,
  input  zvc_sts_t sts,
  output zvc_cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_ENCODE
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;
  logic   out_free;
  logic   accept;
  logic   out_load;

  // The output register can take a result when empty or being drained.
  assign out_free = !out_valid || !out_stall;
  assign in_stall = !((state == S_IDLE) && out_free);
  assign accept   = in_valid && !in_stall;

  // Commands to the datapath.
  assign cmd.enc_load = accept && (operation == OP_ENCODE);
  assign cmd.dec_step = accept && (operation == OP_DECODE);
  assign cmd.enc_emit = (state == S_ENCODE) && out_free;

  assign out_load = cmd.enc_emit || (cmd.dec_step && sts.dec_done);

  // Next state and output valid.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.enc_load) state_next = S_ENCODE;
      end
      S_ENCODE: begin
        if (cmd.enc_emit && sts.enc_final) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase

    if (out_load) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // A result must never overwrite one that is still held by the receiver.
  `ZVC_ASSERT(a_no_overwrite, !(out_load && out_valid && out_stall), "result overwritten")
  // No transaction is taken while an encode is still emitting bytes.
  `ZVC_ASSERT_IMP(a_enc_blocks_input, state == S_ENCODE, in_stall, "input open during encode")
  // Loading an encode always leads to a pending result byte next.
  `ZVC_ASSERT_NEXT(a_enc_starts, cmd.enc_load, state == S_ENCODE, "encode not started")

endmodule

@@ sv/zvc_datapath.sv @@
// Datapath of the zig-zag varint codec: encode shift register, decode accumulator
// and the output register. Depends on zvc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module zvc_datapath import zvc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  zvc_cmd_t           cmd,
  output zvc_sts_t           sts,
  input  logic signed [63:0] value_in,
  input  logic [7:0]         byte_in,
  input  logic               end_of_buffer,
  output logic [1:0]         status,
  output logic [7:0]         out_byte,
  output logic signed [63:0] decoded_value,
  output logic [3:0]         bytes_used,
  output logic               last
);

  logic [63:0] enc_shift;
  logic [63:0] accumulator;
  logic [3:0]  byte_count;

  logic [63:0] zz_value;
  logic [3:0]  idx;
  logic [6:0]  shamt_wide;
  logic [63:0] acc_new;
  logic [3:0]  used;
  logic        is_cont;
  logic [1:0]  dec_status;
  logic [63:0] dec_value;

  // Zig-zag map of the value to encode.
  assign zz_value = {value_in[62:0], 1'b0} ^ {64{value_in[63]}};

  // The last group is reached when nothing lies above the low seven bits.
  assign sts.enc_final = (enc_shift[63:7] == 57'd0);

  // Decode: place the payload at seven times the byte index; on the tenth byte
  // only the lowest payload bit lands inside the word.
  assign idx        = (byte_count >= MAX_BYTES) ? (MAX_BYTES - 4'd1) : byte_count;
  assign shamt_wide = {idx, 3'b000} - {3'b000, idx};
  assign acc_new    = accumulator | ({57'd0, byte_in[6:0] & PAYLOAD_MASK[6:0]} << shamt_wide[5:0]);
  assign used       = idx + 4'd1;
  assign is_cont    = ((byte_in & CONT_BIT) != 8'd0);
  assign sts.dec_done = !is_cont || (used >= MAX_BYTES) || end_of_buffer;

  // Classify the decode result and undo the zig-zag map.
  always_comb begin
    dec_value = 64'd0;
    if (!is_cont) begin
      dec_status = ST_VALUE;
      dec_value  = {1'b0, acc_new[63:1]} ^ {64{acc_new[0]}};
    end else if (used >= MAX_BYTES) begin
      dec_status = ST_OVERLONG;
    end else begin
      dec_status = ST_TRUNC;
    end
  end

  // Encode shift register.
  always_ff @(posedge clk) begin
    if (cmd.enc_load) begin
      enc_shift <= zz_value;
    end else if (cmd.enc_emit) begin
      enc_shift <= {7'd0, enc_shift[63:7]};
    end
  end

  // Decode state.
  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator <= 64'd0;
      byte_count  <= 4'd0;
    end else if (cmd.dec_step) begin
      if (sts.dec_done) begin
        accumulator <= 64'd0;
        byte_count  <= 4'd0;
      end else begin
        accumulator <= acc_new;
        byte_count  <= used;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.enc_emit) begin
      status        <= ST_BYTE;
      out_byte      <= sts.enc_final ? {1'b0, enc_shift[6:0]}
                                     : (CONT_BIT | {1'b0, enc_shift[6:0]});
      decoded_value <= 64'sd0;
      bytes_used    <= 4'd0;
      last          <= sts.enc_final;
    end else if (cmd.dec_step && sts.dec_done) begin
      status        <= dec_status;
      out_byte      <= 8'd0;
      decoded_value <= dec_value;
      bytes_used    <= used;
      last          <= 1'b1;
    end
  end

  // A number in progress never holds ten bytes.
  `ZVC_ASSERT(a_count_range, byte_count < MAX_BYTES, "byte count out of range")
  // A finished decode leaves the accumulator clear.
  `ZVC_ASSERT_NEXT(a_dec_clear, cmd.dec_step && sts.dec_done, accumulator == 64'd0, "accumulator not cleared")
  // Encode and decode never run in the same cycle.
  `ZVC_ASSERT(a_one_op, !(cmd.enc_emit && cmd.dec_step), "encode and decode overlap")

endmodule

@@ sv/zigzag_varint_codec_unit.sv @@
// Zig-zag varint codec for 64-bit values (one input channel, one result channel).
// Transactions use valid/stall on both sides; a transaction completes when valid is
// high and stall is low at a rising edge of clk.
// Encode (operation 0) takes value_in and returns 1 to 10 byte results, low group
// first, one per cycle while the receiver does not stall; the last carries last = 1.
// The input is stalled until the final byte has been loaded into the output register,
// so an encode occupies the block from its acceptance until all of its bytes have been
// emitted, including any time in which the receiver stalls.
// Decode (operation 1) takes one byte per cycle unless the input stalls; a terminating
// byte, a continuation byte with end_of_buffer, or a tenth byte gives one result in
// the next cycle. Other decode bytes give no result. Encodes may sit between bytes of
// one decode. The output register is a single stage: while the receiver stalls a held
// result, the input side stalls too.
// Synchronous reset (rst) empties the output register, returns to idle and clears
// the decode accumulator and byte count. No clearing pass is needed.
// Depends on zvc_pkg, zvc_ctrl and zvc_datapath.
module zigzag_varint_codec_unit import zvc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               operation,
  input  logic signed [63:0] value_in,
  input  logic [7:0]         byte_in,
  input  logic               end_of_buffer,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic [7:0]         out_byte,
  output logic signed [63:0] decoded_value,
  output logic [3:0]         bytes_used,
  output logic               last
);

  zvc_cmd_t cmd;
  zvc_sts_t sts;

  // Handshake and encode sequencing.
  zvc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Shift register, accumulator and output register.
  zvc_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .value_in      (value_in),
    .byte_in       (byte_in),
    .end_of_buffer (end_of_buffer),
    .status        (status),
    .out_byte      (out_byte),
    .decoded_value (decoded_value),
    .bytes_used    (bytes_used),
    .last          (last)
  );

endmodule

@@ sim/tb_zigzag_varint_codec_unit.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for zigzag_varint_codec_unit: a directed stimulus table, then
// random encode and decode traffic checked against an in-bench zig-zag varint predictor.
// Depends on zvc_pkg and the codec RTL.
module tb_zigzag_varint_codec_unit;
  import zvc_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RANDOM_ITEMS = 455;
  localparam int GAP_PCT      = 19;
  localparam int QUIET_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 10;

  // One result transaction as the block presents it.
  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  out_byte;
    logic [63:0] dec_value;
    logic [3:0]  used;
    logic        last;
  } codec_result_t;

  // One row of the directed table; known rows carry their result typed in.
  typedef struct {
    logic          op;
    logic [63:0]   value;
    logic [7:0]    data_byte;
    logic          eob;
    logic          known;
    codec_result_t res;
  } stim_row_t;

  logic               clk           = 1'b0;
  logic               rst           = 1'b1;
  logic               in_valid      = 1'b0;
  logic               operation     = OP_ENCODE;
  logic signed [63:0] value_in      = '0;
  logic [7:0]         byte_in       = '0;
  logic               end_of_buffer = 1'b0;
  logic               out_stall     = 1'b0;
  logic               in_stall;
  logic               out_valid;
  logic [1:0]         status;
  logic [7:0]         out_byte;
  logic signed [63:0] decoded_value;
  logic [3:0]         bytes_used;
  logic               last;

  // Predictor state: payload gathered so far and bytes of the current number.
  logic [63:0]   dec_acc   = '0;
  logic [3:0]    dec_count = '0;

  codec_result_t expected_results[$];
  codec_result_t step_results[$];
  stim_row_t     dir_rows[$];
  int            items_sent     = 0;
  int            mismatch_count = 0;
  int            quiet_cycles   = 0;
  logic          gaps_on        = 1'b1;

  zigzag_varint_codec_unit u_dut (.*);

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Work out the results that one input transaction causes and advance the decode state.
  function automatic void predict_codec(input logic op, input logic [63:0] v,
                                        input logic [7:0] b, input logic eob);
    logic [63:0]   z;
    logic [3:0]    idx;
    logic [3:0]    used;
    codec_result_t r;
    step_results.delete();
    r = '0;
    if (op == OP_ENCODE) begin
      z = (v << 1) ^ {64{v[63]}};
      r.status = ST_BYTE;
      while ((z >> 7) != 64'd0) begin
        r.out_byte = (z[7:0] & PAYLOAD_MASK) | CONT_BIT;
        step_results = {step_results, r};
        z = z >> 7;
      end
      r.out_byte = z[7:0];
      r.last = 1'b1;
      step_results = {step_results, r};
    end else begin
      idx = (dec_count >= MAX_BYTES) ? MAX_BYTES - 4'd1 : dec_count;
      dec_acc = dec_acc | ({56'd0, b & PAYLOAD_MASK} << (7 * idx));
      used = idx + 4'd1;
      r.used = used;
      r.last = 1'b1;
      if ((b & CONT_BIT) == 8'd0) begin
        r.status = ST_VALUE;
        r.dec_value = (dec_acc >> 1) ^ {64{dec_acc[0]}};
      end else if (used >= MAX_BYTES) begin
        r.status = ST_OVERLONG;
      end else if (eob) begin
        r.status = ST_TRUNC;
      end
      if (((b & CONT_BIT) == 8'd0) || (used >= MAX_BYTES) || eob) begin
        step_results = {step_results, r};
        dec_acc = '0;
        dec_count = '0;
      end else begin
        dec_count = used;
      end
    end
  endfunction

  function automatic codec_result_t known_result(input logic [1:0] st, input logic [7:0] ob,
                                                 input logic [63:0] dv, input logic [3:0] used);
    codec_result_t r;
    r = '{status: st, out_byte: ob, dec_value: dv, used: used, last: 1'b1};
    return r;
  endfunction

  function automatic void dir_row(input logic op, input logic [63:0] v, input logic [7:0] b,
                                  input logic eob, input logic known, input codec_result_t res);
    stim_row_t row;
    row = '{op: op, value: v, data_byte: b, eob: eob, known: known, res: res};
    dir_rows = {dir_rows, row};
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  // Offer one input transaction after a random gap, then record what it should cause.
  task automatic send_item(input logic op, input logic [63:0] v, input logic [7:0] b,
                           input logic eob, input logic known, input codec_result_t known_res);
    while (gaps_on && ($urandom_range(99) < GAP_PCT)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    operation     <= op;
    value_in      <= v;
    byte_in       <= b;
    end_of_buffer <= eob;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_codec(op, v, b, eob);
    if (known) begin
      expected_results = {expected_results, known_res};
    end else begin
      expected_results = {expected_results, step_results};
    end
    items_sent++;
  endtask

  // Encode transaction with junk in the decode-only fields.
  task automatic send_encode(input logic [63:0] v);
    send_item(OP_ENCODE, v, 8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0, '0);
  endtask

  // Decode transaction with junk in the encode-only field.
  task automatic send_byte(input logic [7:0] b, input logic eob);
    send_item(OP_DECODE, {$urandom, $urandom}, b, eob, 1'b0, '0);
  endtask

  // Hold the input side idle until every expected result has been taken.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  // Random value with a spread of varint lengths and both signs, extremes now and then.
  function automatic logic [63:0] random_value();
    logic [63:0] v;
    case ($urandom_range(19))
      0: v = 64'h8000_0000_0000_0000;
      1: v = 64'h7FFF_FFFF_FFFF_FFFF;
      2: v = '0;
      3: v = '1;
      default: begin
        v = {$urandom, $urandom} >> $urandom_range(63);
        if ($urandom_range(1)) v = ~v;
      end
    endcase
    return v;
  endfunction

  // Receiver: stall at random outside the full-rate stretch.
  always @(posedge clk) begin
    out_stall <= gaps_on && ($urandom_range(99) < GAP_PCT);
  end

  // Compare each result transaction with the oldest expectation; watch for a hang.
  always @(posedge clk) begin
    codec_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result, status %0d byte %h", status, out_byte));
      end else begin
        want = expected_results.pop_front();
        if (status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
        if (out_byte !== want.out_byte)
          report_mismatch($sformatf("out_byte %h, expected %h", out_byte, want.out_byte));
        if (decoded_value !== want.dec_value)
          report_mismatch($sformatf("decoded_value %h, expected %h", decoded_value,
                                    want.dec_value));
        if (bytes_used !== want.used)
          report_mismatch($sformatf("bytes_used %0d, expected %0d", bytes_used, want.used));
        if (last !== want.last)
          report_mismatch($sformatf("last %b, expected %b", last, want.last));
      end
    end
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[%0t] no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    logic [7:0]  seq [10];
    logic [63:0] z;
    int          n;
    int          split;
    int          k;
    int          sel;
    int          rand_done;
    logic        pressure_done;
    pressure_done = 1'b0;

    // Directed table: reset state, field extremes, both operations and the error cases.
    dir_row(OP_DECODE, '1, 8'h00, 1'b0, 1'b1, known_result(ST_VALUE, 8'h00, 64'd0, 4'd1));
    dir_row(OP_ENCODE, 64'd0, 8'hFF, 1'b1, 1'b1, known_result(ST_BYTE, 8'h00, 64'd0, 4'd0));
    dir_row(OP_ENCODE, '1, 8'h00, 1'b0, 1'b1, known_result(ST_BYTE, 8'h01, 64'd0, 4'd0));
    dir_row(OP_ENCODE, 64'd63, 8'h80, 1'b1, 1'b1, known_result(ST_BYTE, 8'h7E, 64'd0, 4'd0));
    dir_row(OP_ENCODE, 64'hFFFF_FFFF_FFFF_FFC0, 8'h7F, 1'b0, 1'b1,
            known_result(ST_BYTE, 8'h7F, 64'd0, 4'd0));
    dir_row(OP_ENCODE, 64'h7FFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, '0);
    dir_row(OP_ENCODE, 64'h8000_0000_0000_0000, 8'hFF, 1'b1, 1'b0, '0);
    // A terminating byte wins over end_of_buffer.
    dir_row(OP_DECODE, 64'd0, 8'h01, 1'b1, 1'b1, known_result(ST_VALUE, 8'h00, '1, 4'd1));
    dir_row(OP_DECODE, '1, 8'h7F, 1'b0, 1'b1,
            known_result(ST_VALUE, 8'h00, 64'hFFFF_FFFF_FFFF_FFC0, 4'd1));
    // Truncation on the first byte and on the second.
    dir_row(OP_DECODE, 64'd0, 8'h80, 1'b1, 1'b1, known_result(ST_TRUNC, 8'h00, 64'd0, 4'd1));
    dir_row(OP_DECODE, 64'd0, 8'h85, 1'b0, 1'b0, '0);
    dir_row(OP_DECODE, 64'd0, 8'h80, 1'b1, 1'b1, known_result(ST_TRUNC, 8'h00, 64'd0, 4'd2));
    // Overlong number with an encode in the middle; the tenth byte also carries end_of_buffer.
    for (int i = 0; i < 4; i++) dir_row(OP_DECODE, '1, 8'hFF, 1'b0, 1'b0, '0);
    dir_row(OP_ENCODE, 64'd1, 8'hFF, 1'b1, 1'b1, known_result(ST_BYTE, 8'h02, 64'd0, 4'd0));
    for (int i = 0; i < 5; i++) dir_row(OP_DECODE, '1, 8'hFF, 1'b0, 1'b0, '0);
    dir_row(OP_DECODE, '1, 8'hFF, 1'b1, 1'b1, known_result(ST_OVERLONG, 8'h00, 64'd0, 4'd10));
    // A two-byte number after the error.
    dir_row(OP_DECODE, 64'd0, 8'h96, 1'b0, 1'b0, '0);
    dir_row(OP_DECODE, 64'd0, 8'h01, 1'b0, 1'b0, '0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].op, dir_rows[i].value, dir_rows[i].data_byte, dir_rows[i].eob,
                dir_rows[i].known, dir_rows[i].res);
    end
    wait_for_results();

    // Random traffic: mostly well-formed numbers, with encodes, breaks and noise mixed in.
    while (items_sent < dir_rows.size() + RANDOM_ITEMS) begin
      sel = $urandom_range(99);
      if (sel < 30) begin
        send_encode(random_value());
      end else if (sel < 70) begin
        z = random_value();
        z = (z << 1) ^ {64{z[63]}};
        n = 0;
        while ((z >> 7) != 64'd0) begin
          seq[n] = CONT_BIT | {1'b0, z[6:0]};
          z = z >> 7;
          n++;
        end
        seq[n] = {1'b0, z[6:0]};
        n++;
        // On a tenth byte the payload bits above the lowest must be ignored.
        if (n == 10 && $urandom_range(1)) seq[9][6:1] = 6'($urandom_range(63));
        split = ($urandom_range(99) < 15) ? $urandom_range(n - 1) : -1;
        for (int i = 0; i < n; i++) begin
          if (i == split) send_encode(random_value());
          send_byte(seq[i], (i == n - 1) ? 1'($urandom_range(1)) : 1'b0);
        end
      end else if (sel < 78) begin
        k = $urandom_range(9, 1);
        for (int i = 0; i < k - 1; i++) send_byte(CONT_BIT | 8'($urandom_range(127)), 1'b0);
        send_byte(CONT_BIT | 8'($urandom_range(127)), 1'b1);
      end else if (sel < 84) begin
        for (int i = 0; i < 10; i++) begin
          send_byte(CONT_BIT | 8'($urandom_range(127)),
                    (i == 9) ? 1'($urandom_range(1)) : 1'b0);
        end
      end else begin
        repeat ($urandom_range(3, 1)) send_byte(8'($urandom_range(255)), $urandom_range(99) < 25);
      end

      // A long stretch at full rate on both sides, then one pause until all results are in.
      rand_done = items_sent - dir_rows.size();
      gaps_on <= !(rand_done >= 160 && rand_done < 280);
      if (!pressure_done && rand_done >= 300) begin
        wait_for_results();
        pressure_done = 1'b1;
      end
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
